// ----- src/q2e_pkg.sv -----
`default_nettype none
package q2e_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int CW           = 36;
    localparam int ZW           = 28;
    localparam int DIV_STEPS    = 30;
    localparam int SQRT_STEPS   = 31;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(26353589);
    localparam logic signed [30:0]   DEG_MUL     = 31'(480631834);

    typedef struct packed {
        logic signed [15:0] quat_real;
        logic signed [15:0] quat_i;
        logic signed [15:0] quat_j;
        logic signed [15:0] quat_k;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic               range_flag;
    } euler_t;

    typedef struct packed {
        logic signed [CW-1:0] yx;
        logic signed [CW-1:0] yy;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic [32:0]          mag;
        logic [32:0]          norm;
        logic                 num_neg;
        logic                 zero;
        logic                 clamp;
        logic                 bypass;
    } front_t;

    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = ZW'(13176795);
            1:       r = ZW'(7778716);
            2:       r = ZW'(4110060);
            3:       r = ZW'(2086331);
            4:       r = ZW'(1047214);
            5:       r = ZW'(524117);
            6:       r = ZW'(262123);
            7:       r = ZW'(131069);
            default: r = ZW'(65536) >>> (i - 8);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/q2e_front.sv -----
`default_nettype none
module q2e_front
    import q2e_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire quat_t  quat,
    output logic        rdy,
    input  wire logic   mq_full,
    output logic        mq_push,
    output front_t      mq_data
);

    logic               f1_v_reg;
    logic signed [31:0] sr_reg, si_reg, sj_reg, sk_reg;
    logic signed [31:0] pij_reg, pkr_reg, pjk_reg, pir_reg, pjr_reg, pik_reg;
    logic               f2_v_reg;
    front_t             f2_reg, f2_next;
    logic               fe;

    logic signed [33:0] num;
    logic signed [33:0] yx, yy, rx, ry;

    assign fe      = !f2_v_reg || !mq_full;
    assign rdy     = fe;
    assign mq_push = f2_v_reg && !mq_full;
    assign mq_data = f2_reg;

    always_comb
    begin
        num = (34'(pjr_reg) - 34'(pik_reg)) <<< 1;
        yx  = 34'(si_reg) - 34'(sj_reg) - 34'(sk_reg) + 34'(sr_reg);
        yy  = (34'(pij_reg) + 34'(pkr_reg)) <<< 1;
        rx  = 34'(sk_reg) + 34'(sr_reg) - 34'(si_reg) - 34'(sj_reg);
        ry  = (34'(pjk_reg) + 34'(pir_reg)) <<< 1;
        f2_next.yx   = CW'(yx);
        f2_next.yy   = CW'(yy);
        f2_next.rx   = CW'(rx);
        f2_next.ry   = CW'(ry);
        f2_next.norm = 33'(sr_reg) + 33'(si_reg) + 33'(sj_reg) + 33'(sk_reg);
        f2_next.num_neg = num[33];
        f2_next.mag  = num[33] ? 33'(-num) : 33'(num);
        f2_next.zero = (f2_next.norm == '0);
        f2_next.bypass = (f2_next.mag >= f2_next.norm);
        f2_next.clamp  = (f2_next.mag > f2_next.norm) || f2_next.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else if (fe)
        begin
            f1_v_reg <= push;
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            sr_reg  <= quat.quat_real * quat.quat_real;
            si_reg  <= quat.quat_i * quat.quat_i;
            sj_reg  <= quat.quat_j * quat.quat_j;
            sk_reg  <= quat.quat_k * quat.quat_k;
            pij_reg <= quat.quat_i * quat.quat_j;
            pkr_reg <= quat.quat_k * quat.quat_real;
            pjk_reg <= quat.quat_j * quat.quat_k;
            pir_reg <= quat.quat_i * quat.quat_real;
            pjr_reg <= quat.quat_j * quat.quat_real;
            pik_reg <= quat.quat_i * quat.quat_k;
            f2_reg  <= f2_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/q2e_mid_queue.sv -----
`default_nettype none
module q2e_mid_queue
    import q2e_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr,
    input  wire front_t wdata,
    output logic        full,
    input  wire logic   rd,
    output logic        nonempty,
    output front_t      rdata
);

    front_t     mem_reg [0:1];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign rdata    = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

endmodule
`default_nettype wire

// ----- src/q2e_back.sv -----
`default_nettype none
module q2e_back
    import q2e_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   deg_mode,
    input  wire logic   mq_nonempty,
    input  wire front_t mq_data,
    output logic        mq_pop,
    output logic        empty,
    input  wire logic   pop,
    output euler_t      angles
);

    localparam int K_SQ   = DIV_STEPS;
    localparam int K_SQRT = K_SQ + 1;
    localparam int K_PRE  = K_SQRT + SQRT_STEPS;
    localparam int K_CRD  = K_PRE + 1;
    localparam int L      = K_CRD + CORDIC_N;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]  ln;
        logic         num_neg;
        logic         zero;
        logic         clamp;
        logic         bypass;
        logic [33:0]  rem;
        logic [32:0]  den;
        logic [29:0]  quo;
        logic [60:0]  sv;
        logic [60:0]  sr;
    } bk_t;

    function automatic lane_t prerot(input lane_t a);
        lane_t b;
        b = a;
        if (a.x < 0)
        begin
            if (a.y >= 0)
            begin
                b.x = a.y;
                b.y = -a.x;
                b.z = ANG_HALF_PI;
            end
            else
            begin
                b.x = -a.y;
                b.y = a.x;
                b.z = -ANG_HALF_PI;
            end
        end
        return b;
    endfunction

    function automatic lane_t cstep(input lane_t a, input int i);
        lane_t b;
        b = a;
        if (a.y > 0)
        begin
            b.x = a.x + (a.y >>> i);
            b.y = a.y - (a.x >>> i);
            b.z = a.z + atan_val(i);
        end
        else if (a.y < 0)
        begin
            b.x = a.x - (a.y >>> i);
            b.y = a.y + (a.x >>> i);
            b.z = a.z - atan_val(i);
        end
        return b;
    endfunction

    function automatic bk_t bstep(input bk_t a, input int k);
        bk_t          b;
        logic [33:0]  r2;
        logic [59:0]  sq;
        logic [61:0]  t;
        logic [60:0]  bitv;
        b = a;
        if (k < K_SQ)
        begin
            // restoring divide, one quotient bit per stage
            r2 = {a.rem[32:0], 1'b0};
            if (r2 >= {1'b0, a.den})
            begin
                b.rem = r2 - {1'b0, a.den};
                b.quo = {a.quo[28:0], 1'b1};
            end
            else
            begin
                b.rem = r2;
                b.quo = {a.quo[28:0], 1'b0};
            end
        end
        else if (k == K_SQ)
        begin
            sq   = a.quo * a.quo;
            b.sv = (61'd1 << 60) - 61'(sq);
            b.sr = '0;
        end
        else if (k < K_PRE)
        begin
            bitv = 61'd1 << (60 - 2 * (k - K_SQRT));
            t    = 62'(a.sr) + 62'(bitv);
            if (62'(a.sv) >= t)
            begin
                b.sv = a.sv - 61'(t);
                b.sr = (a.sr >> 1) + bitv;
            end
            else
            begin
                b.sr = a.sr >> 1;
            end
        end
        else if (k == K_PRE)
        begin
            b.ln[1].x = CW'(a.sr[30:0]);
            b.ln[1].y = a.num_neg ? -CW'(a.quo) : CW'(a.quo);
            b.ln[1].z = '0;
            if (a.zero)
            begin
                b.ln[1].x = '0;
                b.ln[1].y = '0;
            end
            else if (a.bypass)
            begin
                b.ln[1].x = '0;
                b.ln[1].y = '0;
                b.ln[1].z = a.num_neg ? -ANG_HALF_PI : ANG_HALF_PI;
            end
            for (int j = 0; j < 3; j++)
                b.ln[j] = prerot(b.ln[j]);
        end
        else
        begin
            for (int j = 0; j < 3; j++)
                b.ln[j] = cstep(a.ln[j], k - K_CRD);
        end
        return b;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767)
            r = 16'sh7fff;
        else if (v < -32'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    bk_t                  st_reg [0:L];
    logic [L:0]           v_reg;
    bk_t                  ld;
    logic                 be;

    logic                 oa_v_reg;
    logic signed [57:0]   prod_reg [0:2];
    logic signed [ZW-1:0] z_reg [0:2];
    logic                 flag_reg;

    euler_t               res;
    euler_t               oq_reg [0:1];
    logic                 owp_reg, orp_reg;
    logic [1:0]           ocnt_reg;
    logic                 opush, opop;

    assign be     = !oa_v_reg || (ocnt_reg != 2'd2);
    assign mq_pop = be && mq_nonempty;
    assign opush  = oa_v_reg && be;
    assign empty  = (ocnt_reg == 2'd0);
    assign opop   = pop && !empty;
    assign angles = oq_reg[orp_reg];

    always_comb
    begin
        ld           = '0;
        ld.ln[0].x   = mq_data.yx;
        ld.ln[0].y   = mq_data.yy;
        ld.ln[2].x   = mq_data.rx;
        ld.ln[2].y   = mq_data.ry;
        ld.num_neg   = mq_data.num_neg;
        ld.zero      = mq_data.zero;
        ld.clamp     = mq_data.clamp;
        ld.bypass    = mq_data.bypass;
        ld.rem       = {1'b0, mq_data.mag};
        ld.den       = mq_data.norm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            oa_v_reg <= 1'b0;
        end
        else if (be)
        begin
            v_reg    <= {v_reg[L-1:0], mq_nonempty};
            oa_v_reg <= v_reg[L];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
            st_reg[0] <= ld;
    end

    for (genvar k = 0; k < L; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (be)
                st_reg[k+1] <= bstep(st_reg[k], k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[j] <= st_reg[L].ln[j].z * DEG_MUL;
                z_reg[j]    <= st_reg[L].ln[j].z;
            end
            flag_reg <= st_reg[L].clamp;
        end
    end

    always_comb
    begin
        logic signed [16:0] a [0:2];
        for (int j = 0; j < 3; j++)
        begin
            if (deg_mode)
                a[j] = 17'((59'(prod_reg[j]) + (59'sd1 <<< 39)) >>> 40);
            else
                a[j] = 17'((29'(z_reg[j]) + 29'sd1024) >>> 11);
        end
        res.yaw        = sat16(32'(a[0]));
        res.pitch      = sat16(32'(a[1]));
        res.roll       = sat16(32'(a[2]));
        res.range_flag = flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= 1'b0;
            orp_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            if (opush)
                owp_reg <= !owp_reg;
            if (opop)
                orp_reg <= !orp_reg;
            ocnt_reg <= ocnt_reg + 2'(opush) - 2'(opop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (opush)
            oq_reg[owp_reg] <= res;
    end

endmodule
`default_nettype wire

// ----- src/quaternion_to_euler_core.sv -----
// Channel  | Handshake        | Payload
// ---------+------------------+---------------------------------------
// input    | push / full      | quat   (quat_real, quat_i, quat_j, quat_k)
// result   | empty / pop      | angles (yaw, pitch, roll, range_flag)
// config   | cfg_we           | cfg_wdata (angle_in_degrees, reset 1)
//
// One request per cycle sustained while full is low; an accepted request passes
// through 2 product stages, middle queue, load, 30-step divider, square, 31-step
// square root, pre-rotation, one stage per CORDIC step, scaling and the output
// queue to the result ports. The front and back pipelines stall independently
// through a two-entry queue; results wait in a two-entry output queue.
// Async reset clears only valid bits and queue pointers and sets the mode bit to 1.
`default_nettype none
module quaternion_to_euler_core
    import q2e_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire quat_t quat,
    output logic       empty,
    input  wire logic  pop,
    output euler_t     angles,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata
);

    logic   deg_reg;
    logic   rdy;
    logic   mq_full, mq_push, mq_pop, mq_nonempty;
    front_t mq_wdata, mq_rdata;

    assign full = !rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deg_reg <= 1'b1;
        else if (cfg_we)
            deg_reg <= cfg_wdata;
    end

    q2e_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .quat    (quat),
        .rdy     (rdy),
        .mq_full (mq_full),
        .mq_push (mq_push),
        .mq_data (mq_wdata)
    );

    q2e_mid_queue u_mq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (mq_push),
        .wdata    (mq_wdata),
        .full     (mq_full),
        .rd       (mq_pop),
        .nonempty (mq_nonempty),
        .rdata    (mq_rdata)
    );

    q2e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .deg_mode    (deg_reg),
        .mq_nonempty (mq_nonempty),
        .mq_data     (mq_rdata),
        .mq_pop      (mq_pop),
        .empty       (empty),
        .pop         (pop),
        .angles      (angles)
    );

endmodule
`default_nettype wire
